### src/vtr_pkg.sv
`timescale 1ns / 1ps
// vtr_pkg: types, widths and constants shared by the voigt rotation pipeline
// depends on nothing; used by every module in src

package vtr_pkg;

    // field and datapath widths
    localparam int Q_W   = 16;            // signed q2.14 matrix entry
    localparam int D_W   = 24;            // signed vector component
    localparam int P_W   = 2 * Q_W;       // entry times entry, q4.28
    localparam int C_W   = P_W + 1;       // voigt coefficient, doubled or summed
    localparam int T_W   = C_W + D_W;     // coefficient times component
    localparam int PS_W  = T_W + 1;       // sum of two terms
    localparam int S_W   = T_W + 3;       // exact sum of six terms
    localparam int FRAC  = 28;            // fraction bits of the sum
    localparam int RES_W = S_W - FRAC;    // integer part of the sum
    localparam int ROW_W = 3 * Q_W;       // one packed matrix row
    localparam int CFG_IDX_W = 2;

    localparam logic [S_W-1:0] ROUND_HALF = S_W'(1) << (FRAC - 1);

    // reset matrix is the identity
    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

    // voigt index pairs, order 11 22 33 12 13 23
    localparam logic [5:0][1:0] PAIR_M = {2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0};
    localparam logic [5:0][1:0] PAIR_N = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0      = 2'd0,
        CFG_ROT_ROW1      = 2'd1,
        CFG_ROT_ROW2      = 2'd2,
        CFG_USE_TRANSPOSE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  mode;
        logic signed [D_W-1:0] comp_11;
        logic signed [D_W-1:0] comp_22;
        logic signed [D_W-1:0] comp_33;
        logic signed [D_W-1:0] comp_12;
        logic signed [D_W-1:0] comp_13;
        logic signed [D_W-1:0] comp_23;
    } t_in;

    typedef struct packed {
        logic signed [D_W-1:0] out_11;
        logic signed [D_W-1:0] out_22;
        logic signed [D_W-1:0] out_33;
        logic signed [D_W-1:0] out_12;
        logic signed [D_W-1:0] out_13;
        logic signed [D_W-1:0] out_23;
        logic                  saturated;
    } t_out;

    typedef logic [2:0][2:0][Q_W-1:0] t_mat;     // [row][col]
    typedef logic [5:0][D_W-1:0]      t_vec;     // voigt components
    typedef logic [5:0][5:0][C_W-1:0] t_coef;    // [out][in]
    typedef logic [5:0][2:0][PS_W-1:0] t_psum;   // [out][pair]

endpackage

### src/vtr_coef.sv
`timescale 1ns / 1ps
// vtr_coef: first two pipeline stages, entry products then 6x6 voigt coefficients
// depends on vtr_pkg

module vtr_coef (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vtr_pkg::t_mat i_mat,
    input  logic          i_mode,
    input  vtr_pkg::t_vec i_vec,
    output logic          o_valid,
    input  logic          i_ready,
    output vtr_pkg::t_coef o_coef,
    output vtr_pkg::t_vec o_vec
);

    logic                      r_v1;
    logic                      r_v2;
    logic                      n_en1;
    logic                      n_en2;
    logic                      r_mode1;
    vtr_pkg::t_vec             r_vec1;
    vtr_pkg::t_vec             r_vec2;
    logic [vtr_pkg::P_W-1:0]   n_pa [6][6];
    logic [vtr_pkg::P_W-1:0]   n_pb [6][6];
    logic [vtr_pkg::P_W-1:0]   r_pa [6][6];
    logic [vtr_pkg::P_W-1:0]   r_pb [6][6];
    vtr_pkg::t_coef            n_coef;
    vtr_pkg::t_coef            r_coef;

    assign n_en2   = !r_v2 || i_ready;
    assign n_en1   = !r_v1 || n_en2;
    assign o_ready = n_en1;
    assign o_valid = r_v2;
    assign o_coef  = r_coef;
    assign o_vec   = r_vec2;

    for (genvar gi = 0; gi < 6; gi++) begin : g_row
        for (genvar gj = 0; gj < 6; gj++) begin : g_col
            localparam int M = int'(vtr_pkg::PAIR_M[gi]);
            localparam int N = int'(vtr_pkg::PAIR_N[gi]);
            localparam int K = int'(vtr_pkg::PAIR_M[gj]);
            localparam int L = int'(vtr_pkg::PAIR_N[gj]);

            assign n_pa[gi][gj] = vtr_pkg::P_W'($signed(i_mat[M][K]))
                                * vtr_pkg::P_W'($signed(i_mat[N][L]));

            // only shear-by-shear coefficients hold two distinct products
            if (gi >= 3 && gj >= 3) begin : g_two
                assign n_pb[gi][gj] = vtr_pkg::P_W'($signed(i_mat[M][L]))
                                    * vtr_pkg::P_W'($signed(i_mat[N][K]));
                assign n_coef[gi][gj] = {r_pa[gi][gj][vtr_pkg::P_W-1], r_pa[gi][gj]}
                                      + {r_pb[gi][gj][vtr_pkg::P_W-1], r_pb[gi][gj]};
            end else begin : g_one
                assign n_pb[gi][gj] = '0;
                always_comb begin
                    // stress doubles shear columns of normal rows,
                    // strain doubles normal columns of shear rows
                    if ((gi < 3 && gj >= 3 && !r_mode1) || (gi >= 3 && gj < 3 && r_mode1)) begin
                        n_coef[gi][gj] = {r_pa[gi][gj], 1'b0};
                    end else begin
                        n_coef[gi][gj] = {r_pa[gi][gj][vtr_pkg::P_W-1], r_pa[gi][gj]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_v1 <= i_valid;
            end
            if (n_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en1) begin
            r_mode1 <= i_mode;
            r_vec1  <= i_vec;
            r_pa    <= n_pa;
            r_pb    <= n_pb;
        end
        if (n_en2) begin
            r_coef <= n_coef;
            r_vec2 <= r_vec1;
        end
    end

endmodule

### src/vtr_mac.sv
`timescale 1ns / 1ps
// vtr_mac: stages three and four, coefficient times component, then pair sums
// depends on vtr_pkg

module vtr_mac (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vtr_pkg::t_coef i_coef,
    input  vtr_pkg::t_vec  i_vec,
    output logic           o_valid,
    input  logic           i_ready,
    output vtr_pkg::t_psum o_psum
);

    logic                    r_v3;
    logic                    r_v4;
    logic                    n_en3;
    logic                    n_en4;
    logic [vtr_pkg::T_W-1:0] n_term [6][6];
    logic [vtr_pkg::T_W-1:0] r_term [6][6];
    vtr_pkg::t_psum          n_psum;
    vtr_pkg::t_psum          r_psum;

    assign n_en4   = !r_v4 || i_ready;
    assign n_en3   = !r_v3 || n_en4;
    assign o_ready = n_en3;
    assign o_valid = r_v4;
    assign o_psum  = r_psum;

    for (genvar gi = 0; gi < 6; gi++) begin : g_row
        for (genvar gj = 0; gj < 6; gj++) begin : g_col
            assign n_term[gi][gj] = vtr_pkg::T_W'($signed(i_coef[gi][gj]))
                                  * vtr_pkg::T_W'($signed(i_vec[gj]));
        end
        for (genvar gp = 0; gp < 3; gp++) begin : g_pair
            assign n_psum[gi][gp] =
                {r_term[gi][2*gp][vtr_pkg::T_W-1], r_term[gi][2*gp]}
              + {r_term[gi][2*gp+1][vtr_pkg::T_W-1], r_term[gi][2*gp+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en3) begin
                r_v3 <= i_valid;
            end
            if (n_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en3) begin
            r_term <= n_term;
        end
        if (n_en4) begin
            r_psum <= n_psum;
        end
    end

endmodule

### src/vtr_round.sv
`timescale 1ns / 1ps
// vtr_round: last stage, final sum, round half up, saturate, output register
// depends on vtr_pkg

module vtr_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vtr_pkg::t_psum i_psum,
    output logic           o_valid,
    input  logic           i_ready,
    output vtr_pkg::t_out  o_data
);

    localparam logic signed [vtr_pkg::D_W-1:0] OUT_MAX = {1'b0, {(vtr_pkg::D_W-1){1'b1}}};
    localparam logic signed [vtr_pkg::D_W-1:0] OUT_MIN = {1'b1, {(vtr_pkg::D_W-1){1'b0}}};

    logic                      r_valid;
    logic                      n_en;
    logic [vtr_pkg::S_W-1:0]   n_sum [6];
    logic [vtr_pkg::RES_W-1:0] n_res [6];
    logic [vtr_pkg::D_W-1:0]   n_val [6];
    logic [5:0]                n_clip;
    vtr_pkg::t_out             n_data;
    vtr_pkg::t_out             r_data;

    assign n_en    = !r_valid || i_ready;
    assign o_ready = n_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    for (genvar gi = 0; gi < 6; gi++) begin : g_out
        assign n_sum[gi] = vtr_pkg::S_W'($signed(i_psum[gi][0]))
                         + vtr_pkg::S_W'($signed(i_psum[gi][1]))
                         + vtr_pkg::S_W'($signed(i_psum[gi][2]))
                         + vtr_pkg::ROUND_HALF;
        // floor by dropping the fraction bits
        assign n_res[gi] = n_sum[gi][vtr_pkg::S_W-1:vtr_pkg::FRAC];
        always_comb begin
            n_clip[gi] = 1'b0;
            n_val[gi]  = n_res[gi][vtr_pkg::D_W-1:0];
            if (n_res[gi][vtr_pkg::RES_W-1] &&
                !(&n_res[gi][vtr_pkg::RES_W-2:vtr_pkg::D_W-1])) begin
                n_clip[gi] = 1'b1;
                n_val[gi]  = OUT_MIN;
            end else if (!n_res[gi][vtr_pkg::RES_W-1] &&
                         (|n_res[gi][vtr_pkg::RES_W-2:vtr_pkg::D_W-1])) begin
                n_clip[gi] = 1'b1;
                n_val[gi]  = OUT_MAX;
            end
        end
    end

    always_comb begin
        n_data.out_11    = n_val[0];
        n_data.out_22    = n_val[1];
        n_data.out_33    = n_val[2];
        n_data.out_12    = n_val[3];
        n_data.out_13    = n_val[4];
        n_data.out_23    = n_val[5];
        n_data.saturated = |n_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_data <= n_data;
        end
    end

endmodule

### src/voigt_tensor_rotation_top.sv
`timescale 1ns / 1ps
// throughput: one request per cycle while the output is not stalled; five register stages, each with its own valid bit
// a stalled output fills the bubbles first, ready drops only when all five stages hold data
// reset (synchronous, active low) empties the pipeline, loads the identity matrix
// and selects the matrix as given (use_transpose = 1)
// depends on vtr_pkg, vtr_coef, vtr_mac, vtr_round

module voigt_tensor_rotation_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vtr_pkg::t_in                    i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vtr_pkg::t_out                   o_out_data,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [vtr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vtr_pkg::ROW_W-1:0]       i_cfg_data
);

    // configuration registers
    logic [vtr_pkg::ROW_W-1:0] r_rot_row [3];
    logic                      r_use_transpose;

    // effective matrix and input vector
    vtr_pkg::t_mat  n_mat;
    vtr_pkg::t_vec  n_vec;

    // stage to stage handshakes and payloads
    logic           n_coef_valid;
    logic           n_coef_ready;
    vtr_pkg::t_coef n_coef;
    vtr_pkg::t_vec  n_coef_vec;
    logic           n_mac_valid;
    logic           n_mac_ready;
    vtr_pkg::t_psum n_psum;

    // config writes must only be issued while the pipeline is empty; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_row[0]    <= vtr_pkg::ROT_ROW0_RST;
            r_rot_row[1]    <= vtr_pkg::ROT_ROW1_RST;
            r_rot_row[2]    <= vtr_pkg::ROT_ROW2_RST;
            r_use_transpose <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (vtr_pkg::t_cfg_idx'(i_cfg_idx))
                vtr_pkg::CFG_ROT_ROW0: begin
                    r_rot_row[0] <= i_cfg_data;
                end
                vtr_pkg::CFG_ROT_ROW1: begin
                    r_rot_row[1] <= i_cfg_data;
                end
                vtr_pkg::CFG_ROT_ROW2: begin
                    r_rot_row[2] <= i_cfg_data;
                end
                vtr_pkg::CFG_USE_TRANSPOSE: begin
                    r_use_transpose <= i_cfg_data[0];
                end
            endcase
        end
    end

    // active form reads row r column c, passive form swaps them
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_use_transpose) begin
                    n_mat[r][c] = r_rot_row[r][c*vtr_pkg::Q_W +: vtr_pkg::Q_W];
                end else begin
                    n_mat[r][c] = r_rot_row[c][r*vtr_pkg::Q_W +: vtr_pkg::Q_W];
                end
            end
        end
    end

    // voigt order 11 22 33 12 13 23
    assign n_vec[0] = i_in_data.comp_11;
    assign n_vec[1] = i_in_data.comp_22;
    assign n_vec[2] = i_in_data.comp_33;
    assign n_vec[3] = i_in_data.comp_12;
    assign n_vec[4] = i_in_data.comp_13;
    assign n_vec[5] = i_in_data.comp_23;

    // stages one and two: products of entries, then mode-dependent coefficients
    vtr_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mat   (n_mat),
        .i_mode  (i_in_data.mode),
        .i_vec   (n_vec),
        .o_valid (n_coef_valid),
        .i_ready (n_coef_ready),
        .o_coef  (n_coef),
        .o_vec   (n_coef_vec)
    );

    // stages three and four: 36 multiplies, then sums of pairs
    vtr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_coef_valid),
        .o_ready (n_coef_ready),
        .i_coef  (n_coef),
        .i_vec   (n_coef_vec),
        .o_valid (n_mac_valid),
        .i_ready (n_mac_ready),
        .o_psum  (n_psum)
    );

    // stage five: final add, rounding, saturation; this is the output register
    vtr_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_mac_valid),
        .o_ready (n_mac_ready),
        .i_psum  (n_psum),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // back-pressure on requests only when the output itself is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("request stalled while the output is free");

    // a draining output lets the whole pipeline advance
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("request stalled while a result drains");

    // a request accepted while the output register is empty and ready reaches the output if the output stays ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid && i_out_ready) ##1 i_out_ready
        ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("result missing five cycles after the request");

endmodule

### test/tb_voigt_tensor_rotation_top.sv
`timescale 1ns / 1ps
// tb_voigt_tensor_rotation_top: self-checking bench for the voigt vector rotation block
// predicts each rotated vector in 64-bit integers and compares every field in order
// depends on vtr_pkg and voigt_tensor_rotation_top

module tb_voigt_tensor_rotation_top;

    localparam int      PIPE_LAT   = 5;              // request to result through the rtl pipeline
    localparam longint  TIMEOUT_NS = 64'd8_000_000;  // far above the slowest run
    localparam longint  HALF_LSB   = 64'sd1 <<< 27;  // one half in q.28
    localparam longint  OUT_HI     = 64'sd8388607;
    localparam longint  OUT_LO     = -64'sd8388608;

    localparam logic MODE_STRESS = 1'b0;
    localparam logic MODE_STRAIN = 1'b1;
    localparam logic AS_GIVEN    = 1'b1;
    localparam logic TRANSPOSED  = 1'b0;

    localparam logic signed [vtr_pkg::D_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [vtr_pkg::D_W-1:0] CMIN = 24'sh800000;

    // voigt index pairs 11 22 33 12 13 23, element 0 first
    localparam logic [5:0][1:0] IDX_M = {2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0};
    localparam logic [5:0][1:0] IDX_N = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    vtr_pkg::t_in                  i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    vtr_pkg::t_out                 o_out_data;
    logic                          i_cfg_we;
    logic [vtr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [vtr_pkg::ROW_W-1:0]     i_cfg_data;

    // mirror of the configuration registers
    logic [vtr_pkg::ROW_W-1:0]  row_cfg [3];
    logic                       as_given;

    vtr_pkg::t_out     pending_rotations [$];
    int                mismatch_count;
    bit                src_idle;
    bit                sink_idle;
    int                stall_left;

    voigt_tensor_rotation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // rotated vector for one request under the mirrored matrix
    function automatic vtr_pkg::t_out rotate_voigt(input vtr_pkg::t_in req);
        longint                         r [3][3];
        longint                         v [6];
        longint                         acc;
        longint                         term;
        longint                         res;
        logic signed [vtr_pkg::Q_W-1:0] ent;
        logic [5:0][vtr_pkg::D_W-1:0]   res_v;
        logic                           strain;
        logic                           clipped;
        int                             m, n, k, l;
        vtr_pkg::t_out                  rsp;
        strain  = (req.mode == MODE_STRAIN);
        clipped = 1'b0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                // passive form reads column a of row register b
                ent = as_given ? row_cfg[a][vtr_pkg::Q_W*b +: vtr_pkg::Q_W]
                               : row_cfg[b][vtr_pkg::Q_W*a +: vtr_pkg::Q_W];
                r[a][b] = longint'(ent);
            end
        end
        v[0] = longint'(req.comp_11);
        v[1] = longint'(req.comp_22);
        v[2] = longint'(req.comp_33);
        v[3] = longint'(req.comp_12);
        v[4] = longint'(req.comp_13);
        v[5] = longint'(req.comp_23);
        for (int i = 0; i < 6; i++) begin
            m   = int'(IDX_M[i]);
            n   = int'(IDX_N[i]);
            acc = 0;
            for (int j = 0; j < 6; j++) begin
                k = int'(IDX_M[j]);
                l = int'(IDX_N[j]);
                if (j < 3) begin
                    term = r[m][k] * r[n][k];
                    if (strain && i >= 3) term = term * 2;
                end else if (i < 3) begin
                    term = r[m][k] * r[m][l];
                    if (!strain) term = term * 2;
                end else begin
                    term = r[m][k] * r[n][l] + r[m][l] * r[n][k];
                end
                acc = acc + term * v[j];
            end
            // half rounds toward plus infinity
            res = (acc + HALF_LSB) >>> 28;
            if (res > OUT_HI) begin
                res     = OUT_HI;
                clipped = 1'b1;
            end
            if (res < OUT_LO) begin
                res     = OUT_LO;
                clipped = 1'b1;
            end
            res_v[i] = res[vtr_pkg::D_W-1:0];
        end
        rsp.out_11    = res_v[0];
        rsp.out_22    = res_v[1];
        rsp.out_33    = res_v[2];
        rsp.out_12    = res_v[3];
        rsp.out_13    = res_v[4];
        rsp.out_23    = res_v[5];
        rsp.saturated = clipped;
        return rsp;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random component: extremes or zero now and then, otherwise random magnitude
    function automatic logic signed [vtr_pkg::D_W-1:0] rand_comp();
        logic signed [vtr_pkg::D_W-1:0] x;
        x = vtr_pkg::D_W'($urandom);
        case ($urandom_range(0, 11))
            0:       x = CMAX;
            1:       x = CMIN;
            2:       x = '0;
            default: x = x >>> $urandom_range(0, 22);
        endcase
        return x;
    endfunction

    // random q2.14 entry; full range includes the extreme codes
    function automatic logic [vtr_pkg::Q_W-1:0] rand_entry(input bit full);
        logic signed [vtr_pkg::Q_W-1:0] s;
        s = vtr_pkg::Q_W'($urandom);
        if (full && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0:       s = 16'sh8000;
                1:       s = 16'sh7FFF;
                2:       s = 16'sh4000;
                default: s = 16'shC000;
            endcase
        end else begin
            s = s >>> (full ? $urandom_range(0, 3) : $urandom_range(1, 3));
        end
        return s;
    endfunction

    function automatic logic [vtr_pkg::ROW_W-1:0] pack_row(
        input logic [vtr_pkg::Q_W-1:0] c0, c1, c2);
        return {c2, c1, c0};
    endfunction

    task automatic flag_error(input string what, input longint got, input longint want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // one register write per edge; caller drops the write enable
    task automatic put_reg(input vtr_pkg::t_cfg_idx idx,
                           input logic [vtr_pkg::ROW_W-1:0] word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= word;
        case (idx)
            vtr_pkg::CFG_ROT_ROW0:      row_cfg[0] = word;
            vtr_pkg::CFG_ROT_ROW1:      row_cfg[1] = word;
            vtr_pkg::CFG_ROT_ROW2:      row_cfg[2] = word;
            vtr_pkg::CFG_USE_TRANSPOSE: as_given   = word[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // only call while the pipeline is empty
    task automatic write_config(input logic [3:0] mask,
                                input logic [vtr_pkg::ROW_W-1:0] r0, r1, r2,
                                input logic [vtr_pkg::ROW_W-1:0] tr_word);
        if (mask[vtr_pkg::CFG_ROT_ROW0])      put_reg(vtr_pkg::CFG_ROT_ROW0, r0);
        if (mask[vtr_pkg::CFG_ROT_ROW1])      put_reg(vtr_pkg::CFG_ROT_ROW1, r1);
        if (mask[vtr_pkg::CFG_ROT_ROW2])      put_reg(vtr_pkg::CFG_ROT_ROW2, r2);
        if (mask[vtr_pkg::CFG_USE_TRANSPOSE]) put_reg(vtr_pkg::CFG_USE_TRANSPOSE, tr_word);
        i_cfg_we <= 1'b0;
    endtask

    // drop valid, wait for every result, then let the pipeline settle
    task automatic wait_drain(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rotations.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // one request; valid stays high after acceptance for back-to-back traffic
    task automatic send_vector(input logic mode,
                               input logic signed [vtr_pkg::D_W-1:0] c11, c22, c33,
                               input logic signed [vtr_pkg::D_W-1:0] c12, c13, c23);
        vtr_pkg::t_in req;
        int           gap;
        req.mode    = mode;
        req.comp_11 = c11;
        req.comp_22 = c22;
        req.comp_33 = c33;
        req.comp_12 = c12;
        req.comp_13 = c13;
        req.comp_23 = c23;
        gap = src_idle ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rotations.push_back(rotate_voigt(req));
    endtask

    // identity from reset: every vector passes through unchanged
    task automatic test_reset_identity();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_vector(MODE_STRESS, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_vector(MODE_STRAIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_vector(MODE_STRESS, '0, '0, '0, '0, '0, '0);
        send_vector(MODE_STRAIN, 24'sd1, -24'sd1, CMAX, CMIN, 24'sd12345, -24'sd54321);
        send_vector(MODE_STRESS, CMIN, CMAX, -24'sd1, 24'sd1, '0, 24'sh555555);
        send_vector(MODE_STRAIN, 24'shAAAAAA, 24'sh555555, 24'sh0F0F0F, 24'shF0F0F0,
                    24'sh123456, 24'shEDCBA9);
    endtask

    // half diagonal: exact halves of both signs, ties go up
    task automatic test_rounding();
        wait_drain(PIPE_LAT + 2);
        write_config(4'b0111, pack_row(16'h2000, 16'h0000, 16'h0000),
                     pack_row(16'h0000, 16'h2000, 16'h0000),
                     pack_row(16'h0000, 16'h0000, 16'h2000), '0);
        sink_idle = 1'b1;
        send_vector(MODE_STRESS, 24'sd2, 24'sd2, 24'sd2, 24'sd2, 24'sd2, 24'sd2);
        send_vector(MODE_STRESS, -24'sd2, -24'sd2, -24'sd2, -24'sd2, -24'sd2, -24'sd2);
        send_vector(MODE_STRAIN, 24'sd1, -24'sd1, 24'sd3, -24'sd3, 24'sd2, -24'sd2);
        send_vector(MODE_STRAIN, -24'sd6, 24'sd6, -24'sd2, 24'sd2, -24'sd1, 24'sd1);
    endtask

    // most negative and most positive entries drive sums past 24 bits
    task automatic test_saturation();
        wait_drain(PIPE_LAT + 2);
        write_config(4'b0111, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, '0);
        send_vector(MODE_STRESS, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_vector(MODE_STRESS, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_vector(MODE_STRAIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_vector(MODE_STRAIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        wait_drain(PIPE_LAT + 2);
        write_config(4'b0111, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, '0);
        send_vector(MODE_STRESS, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_vector(MODE_STRAIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    endtask

    // asymmetric matrix in both forms; upper bits of the flag word are junk
    task automatic test_transpose();
        wait_drain(PIPE_LAT + 2);
        write_config(4'b1111, pack_row(16'h0000, 16'hC000, 16'h1000),
                     pack_row(16'h4000, 16'h0000, 16'hF800),
                     pack_row(16'h0800, 16'h2000, 16'h4000),
                     {47'h7FFF_FFFF_FFFF, TRANSPOSED});
        send_vector(MODE_STRESS, 24'sd1000, -24'sd2000, 24'sd3000, 24'sd400, -24'sd500, 24'sd600);
        send_vector(MODE_STRAIN, 24'sd1000, -24'sd2000, 24'sd3000, 24'sd400, -24'sd500, 24'sd600);
        wait_drain(PIPE_LAT + 2);
        write_config(4'b1000, '0, '0, '0, {47'h4000_0000_0000, AS_GIVEN});
        send_vector(MODE_STRESS, 24'sd1000, -24'sd2000, 24'sd3000, 24'sd400, -24'sd500, 24'sd600);
        send_vector(MODE_STRAIN, 24'sd1000, -24'sd2000, 24'sd3000, 24'sd400, -24'sd500, 24'sd600);
    endtask

    // random matrices and vectors, with one full drain in the middle of each phase
    task automatic test_random_rotations();
        logic [vtr_pkg::Q_W-1:0]   ent [3][3];
        logic [vtr_pkg::ROW_W-1:0] tr_word;
        int                        col0, col1, pause_at;
        for (int phase = 0; phase < 8; phase++) begin
            wait_drain(PIPE_LAT + 2);
            case (phase)
                0, 3, 6: begin
                    // signed permutation: a proper or improper right-angle rotation
                    col0 = $urandom_range(0, 2);
                    col1 = (col0 + $urandom_range(1, 2)) % 3;
                    for (int a = 0; a < 3; a++)
                        for (int b = 0; b < 3; b++)
                            ent[a][b] = '0;
                    ent[0][col0]            = $urandom_range(0, 1) ? 16'hC000 : 16'h4000;
                    ent[1][col1]            = $urandom_range(0, 1) ? 16'hC000 : 16'h4000;
                    ent[2][3 - col0 - col1] = $urandom_range(0, 1) ? 16'hC000 : 16'h4000;
                end
                7: begin
                    // smallest negative entries, a zero row and a random row
                    for (int b = 0; b < 3; b++) begin
                        ent[0][b] = 16'hFFFF;
                        ent[1][b] = 16'h0000;
                        ent[2][b] = rand_entry(1'b1);
                    end
                end
                default: begin
                    for (int a = 0; a < 3; a++)
                        for (int b = 0; b < 3; b++)
                            ent[a][b] = rand_entry(phase % 3 == 2);
                end
            endcase
            tr_word    = vtr_pkg::ROW_W'({$urandom, $urandom});
            tr_word[0] = phase[0];
            write_config(4'b1111, pack_row(ent[0][0], ent[0][1], ent[0][2]),
                         pack_row(ent[1][0], ent[1][1], ent[1][2]),
                         pack_row(ent[2][0], ent[2][1], ent[2][2]), tr_word);
            // first phase streams with no idling on either side
            src_idle  = (phase % 3 != 0);
            sink_idle = (phase % 4 != 0);
            pause_at  = $urandom_range(16, 110);
            for (int cnt = 0; cnt < 128; cnt++) begin
                if (cnt == pause_at) wait_drain(0);
                send_vector(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                            rand_comp(), rand_comp(), rand_comp());
            end
        end
    endtask

    // receiver: random stalls while sink_idle is set, otherwise always ready
    initial begin
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0)
                stall_left--;
            else if (sink_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_out_ready <= (stall_left == 0);
        end
    end

    // result checker: oldest expectation against each accepted result
    always @(posedge i_clk) begin : check_results
        vtr_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rotations.size() == 0) begin
                flag_error("result with no request pending", 1, 0);
            end else begin
                want = pending_rotations.pop_front();
                if (o_out_data.out_11 !== want.out_11)
                    flag_error("out_11", o_out_data.out_11, want.out_11);
                if (o_out_data.out_22 !== want.out_22)
                    flag_error("out_22", o_out_data.out_22, want.out_22);
                if (o_out_data.out_33 !== want.out_33)
                    flag_error("out_33", o_out_data.out_33, want.out_33);
                if (o_out_data.out_12 !== want.out_12)
                    flag_error("out_12", o_out_data.out_12, want.out_12);
                if (o_out_data.out_13 !== want.out_13)
                    flag_error("out_13", o_out_data.out_13, want.out_13);
                if (o_out_data.out_23 !== want.out_23)
                    flag_error("out_23", o_out_data.out_23, want.out_23);
                if (o_out_data.saturated !== want.saturated)
                    flag_error("saturated", o_out_data.saturated, want.saturated);
            end
        end
    end

    // main sequence
    initial begin
        mismatch_count = 0;
        src_idle       = 1'b0;
        sink_idle      = 1'b0;
        // reset state of the block: identity, matrix used as given
        row_cfg[0]     = 48'h0000_0000_4000;
        row_cfg[1]     = 48'h0000_4000_0000;
        row_cfg[2]     = 48'h4000_0000_0000;
        as_given       = AS_GIVEN;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= vtr_pkg::CFG_ROT_ROW0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_identity();
        test_rounding();
        test_saturation();
        test_transpose();
        test_random_rotations();

        wait_drain(PIPE_LAT + 4);
        if (mismatch_count == 0)
            $display("voigt_tensor_rotation_top: match");
        else
            $display("voigt_tensor_rotation_top: mismatch");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("voigt_tensor_rotation_top: mismatch");
        $finish;
    end

endmodule

### sim.f
src/vtr_pkg.sv
src/vtr_coef.sv
src/vtr_mac.sv
src/vtr_round.sv
src/voigt_tensor_rotation_top.sv
test/tb_voigt_tensor_rotation_top.sv
